// File: hw/rtl/fcsg_pkg.sv
// Package for the filled circle span generator.
// Holds the coordinate width default, the span, radius, decision and offset widths, the
// function codes and the span index codes. No dependencies.
package fcsg_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int SPAN_BITS      = 16;
  localparam int RADIUS_BITS    = 15;
  localparam int DEC_BITS       = 20;
  localparam int OFS_BITS       = 16;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  localparam logic [1:0] SPAN_FIRST = 2'd0;
  localparam logic [1:0] SPAN_LAST  = 2'd3;

endpackage

// File: hw/rtl/filled_circle_span_generator_top.sv
// Filled circle span generator: midpoint circle stepper plus a four-span output stage.
// Depends on fcsg_pkg.
//
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | func, center_x, center_y, radius
// out_    | output    | out_valid/out_stall| span_row, span_left, span_right, last_of_run,
//         |           |                    | circle_done
//
// A start transaction loads the stepper and yields nothing. An advance taken while the
// stepper runs updates it in the cycle it is taken and yields four spans, one per cycle
// from a snapshot register while out_stall is low (four spans share the one result port);
// an advance taken while the stepper is idle yields nothing. in_stall is high while the
// snapshot holds spans and its last span is not moving to the output register in this
// cycle. Reset (rst_n low, synchronous) clears the stepper to idle and drops all pending spans.
module filled_circle_span_generator_top #(
  parameter int COORD_BITS = fcsg_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_func,
  input  logic signed [fcsg_pkg::SPAN_BITS-1:0] in_center_x,
  input  logic signed [fcsg_pkg::SPAN_BITS-1:0] in_center_y,
  input  logic [fcsg_pkg::RADIUS_BITS-1:0]      in_radius,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fcsg_pkg::SPAN_BITS-1:0] out_span_row,
  output logic signed [fcsg_pkg::SPAN_BITS-1:0] out_span_left,
  output logic signed [fcsg_pkg::SPAN_BITS-1:0] out_span_right,
  output logic                                  out_last_of_run,
  output logic                                  out_circle_done
);
  import fcsg_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RUN   = 2'd1,
    PH_FINAL = 2'd2
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [COORD_BITS-1:0] center_col_r, center_col_nxt;
  logic [COORD_BITS-1:0] center_row_r, center_row_nxt;
  logic [OFS_BITS-1:0]   offset_x_r, offset_x_nxt;
  logic [OFS_BITS-1:0]   offset_y_r, offset_y_nxt;
  logic [DEC_BITS-1:0]   decision_r, decision_nxt;

  // span snapshot
  logic                  s_valid_r;
  logic [1:0]            s_idx_r;
  logic [COORD_BITS-1:0] s_cx_r, s_cy_r;
  logic [OFS_BITS-1:0]   s_x_r, s_y_r;
  logic                  s_done_r;

  // output register
  logic                  out_valid_r;
  logic [SPAN_BITS-1:0]  out_row_r, out_left_r, out_right_r;
  logic                  out_last_r, out_done_r;

  logic                  in_acc;
  logic                  o_load;
  logic                  s_free;
  logic                  s_load;
  logic                  s_done_nxt;
  logic [OFS_BITS-1:0]   x_step, y_step;
  logic [DEC_BITS-1:0]   d_step;
  logic [OFS_BITS-1:0]   row_ofs, col_ofs;
  logic [COORD_BITS-1:0] row_ofs_ext, col_ofs_ext;
  logic [COORD_BITS-1:0] row_val, left_val, right_val;

  assign o_load   = s_valid_r && (!out_valid_r || !out_stall);
  assign s_free   = o_load && (s_idx_r == SPAN_LAST);
  assign in_stall = s_valid_r && !s_free;
  assign in_acc   = in_valid && !in_stall;

  // midpoint step from current state
  always_comb begin
    x_step = offset_x_r + OFS_BITS'(1);
    if (decision_r[DEC_BITS-1]) begin
      d_step = decision_r + (DEC_BITS'(offset_x_r) << 2) + DEC_BITS'(6);
      y_step = offset_y_r;
    end else begin
      d_step = decision_r + ((DEC_BITS'(offset_x_r) - DEC_BITS'(offset_y_r)) << 2)
               + DEC_BITS'(10);
      y_step = offset_y_r - OFS_BITS'(1);
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    center_col_nxt = center_col_r;
    center_row_nxt = center_row_r;
    offset_x_nxt   = offset_x_r;
    offset_y_nxt   = offset_y_r;
    decision_nxt   = decision_r;
    s_load         = 1'b0;
    s_done_nxt     = 1'b0;
    if (in_acc) begin
      if (in_func == FUNC_START) begin
        center_col_nxt = COORD_BITS'(in_center_x);
        center_row_nxt = COORD_BITS'(in_center_y);
        offset_x_nxt   = '0;
        offset_y_nxt   = OFS_BITS'(in_radius);
        decision_nxt   = DEC_BITS'(3) - (DEC_BITS'(in_radius) << 1);
        phase_nxt      = (in_radius != '0) ? PH_RUN : PH_IDLE;
      end else begin
        case (phase_r)
          PH_RUN: begin
            s_load       = 1'b1;
            offset_x_nxt = x_step;
            offset_y_nxt = y_step;
            decision_nxt = d_step;
            if (x_step < y_step) begin
              phase_nxt = PH_RUN;
            end else if (y_step != '0) begin
              phase_nxt = PH_FINAL;
            end else begin
              phase_nxt  = PH_IDLE;
              s_done_nxt = 1'b1;
            end
          end
          PH_FINAL: begin
            s_load       = 1'b1;
            s_done_nxt   = 1'b1;
            offset_x_nxt = offset_y_r;
            phase_nxt    = PH_IDLE;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // span select: odd spans swap offsets, upper two use negative row offset
  always_comb begin
    row_ofs     = s_idx_r[0] ? s_y_r : s_x_r;
    col_ofs     = s_idx_r[0] ? s_x_r : s_y_r;
    row_ofs_ext = COORD_BITS'(row_ofs);
    col_ofs_ext = COORD_BITS'(col_ofs);
    row_val     = s_idx_r[1] ? (s_cy_r - row_ofs_ext) : (s_cy_r + row_ofs_ext);
    left_val    = s_cx_r - col_ofs_ext;
    right_val   = s_cx_r + col_ofs_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      center_col_r <= '0;
      center_row_r <= '0;
      offset_x_r   <= '0;
      offset_y_r   <= '0;
      decision_r   <= '0;
      s_valid_r    <= 1'b0;
      s_idx_r      <= SPAN_FIRST;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      center_col_r <= center_col_nxt;
      center_row_r <= center_row_nxt;
      offset_x_r   <= offset_x_nxt;
      offset_y_r   <= offset_y_nxt;
      decision_r   <= decision_nxt;

      if (s_load) begin
        s_valid_r <= 1'b1;
        s_idx_r   <= SPAN_FIRST;
      end else if (s_free) begin
        s_valid_r <= 1'b0;
        s_idx_r   <= SPAN_FIRST;
      end else if (o_load) begin
        s_idx_r <= s_idx_r + 2'd1;
      end

      if (o_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_load) begin
      s_cx_r   <= center_col_r;
      s_cy_r   <= center_row_r;
      s_x_r    <= (phase_r == PH_FINAL) ? offset_y_r : offset_x_r;
      s_y_r    <= offset_y_r;
      s_done_r <= s_done_nxt;
    end
    if (o_load) begin
      out_row_r   <= SPAN_BITS'(row_val);
      out_left_r  <= SPAN_BITS'(left_val);
      out_right_r <= SPAN_BITS'(right_val);
      out_last_r  <= (s_idx_r == SPAN_LAST);
      out_done_r  <= (s_idx_r == SPAN_LAST) && s_done_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_span_row    = out_row_r;
  assign out_span_left   = out_left_r;
  assign out_span_right  = out_right_r;
  assign out_last_of_run = out_last_r;
  assign out_circle_done = out_done_r;

endmodule

// File: test/testbench.sv
// Self-checking bench for filled_circle_span_generator_top: random circle start/advance
// transactions against a built-in midpoint-circle predictor, random idling on both sides.
// Depends on fcsg_pkg and the filled_circle_span_generator_top RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fcsg_pkg::*;

  typedef enum logic [1:0] {CIRC_IDLE, CIRC_RUN, CIRC_FINAL} circle_phase_t;

  typedef struct {
    logic [SPAN_BITS-1:0] col;
    logic [SPAN_BITS-1:0] row;
    logic [OFS_BITS-1:0] ox;
    logic [OFS_BITS-1:0] oy;
    logic signed [DEC_BITS-1:0] dec;
    circle_phase_t ph;
  } circle_state_t;

  typedef struct {
    logic func;
    logic signed [SPAN_BITS-1:0] cx;
    logic signed [SPAN_BITS-1:0] cy;
    logic [RADIUS_BITS-1:0] radius;
    bit drain;
  } circle_req_t;

  typedef struct {
    logic [SPAN_BITS-1:0] row;
    logic [SPAN_BITS-1:0] left;
    logic [SPAN_BITS-1:0] right;
    logic last;
    logic done;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = FUNC_START;
  logic signed [SPAN_BITS-1:0] in_center_x = '0;
  logic signed [SPAN_BITS-1:0] in_center_y = '0;
  logic [RADIUS_BITS-1:0] in_radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SPAN_BITS-1:0] out_span_row;
  logic signed [SPAN_BITS-1:0] out_span_left;
  logic signed [SPAN_BITS-1:0] out_span_right;
  logic out_last_of_run;
  logic out_circle_done;

  filled_circle_span_generator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_radius(in_radius),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_span_row(out_span_row),
    .out_span_left(out_span_left),
    .out_span_right(out_span_right),
    .out_last_of_run(out_last_of_run),
    .out_circle_done(out_circle_done)
  );

  always #5 clk = ~clk;

  circle_req_t pending_q[$];
  span_t span_q[$];
  circle_state_t circle;
  circle_state_t scratch;
  bit drain_next = 0;
  int drawing_items = 0;
  int mismatch_cnt = 0;
  int accepted_cnt = 0;
  int start_cnt = 0;
  int spans_checked = 0;
  int circles_done = 0;
  bit in_taken = 0;
  int gap_left = 0;
  int burst_left = 1;
  int hold_left = 0;
  int holds_done = 0;
  int stall_mode = 0;
  int mode_left = 0;

  function automatic int step_circle(inout circle_state_t s, input circle_req_t r,
                                     output span_t spans [4]);
    int d;
    logic [OFS_BITS-1:0] x, y, nx, ny;
    circle_phase_t nph;
    logic done;
    for (int i = 0; i < 4; i++) spans[i] = '{default: '0};
    if (r.func == FUNC_START) begin
      s.col = r.cx;
      s.row = r.cy;
      s.ox = '0;
      s.oy = OFS_BITS'(r.radius);
      s.dec = DEC_BITS'(3 - 2 * int'(r.radius));
      s.ph = (r.radius != 0) ? CIRC_RUN : CIRC_IDLE;
      return 0;
    end
    if (s.ph == CIRC_RUN) begin
      x = s.ox;
      y = s.oy;
      d = int'(s.dec);
      ny = y;
      if (d < 0) begin
        d = d + 4 * int'(x) + 6;
      end else begin
        d = d + 4 * (int'(x) - int'(y)) + 10;
        ny = y - 1'b1;
      end
      nx = x + 1'b1;
      if (nx < ny) nph = CIRC_RUN;
      else if (ny != 0) nph = CIRC_FINAL;
      else nph = CIRC_IDLE;
      done = (nph == CIRC_IDLE);
      s.ox = nx;
      s.oy = ny;
      s.dec = DEC_BITS'(d);
      s.ph = nph;
    end else if (s.ph == CIRC_FINAL) begin
      x = s.oy;
      y = s.oy;
      s.ox = y;
      s.ph = CIRC_IDLE;
      done = 1'b1;
    end else begin
      return 0;
    end
    spans[0] = '{s.row + x, s.col - y, s.col + y, 1'b0, 1'b0};
    spans[1] = '{s.row + y, s.col - x, s.col + x, 1'b0, 1'b0};
    spans[2] = '{s.row - x, s.col - y, s.col + y, 1'b0, 1'b0};
    spans[3] = '{s.row - y, s.col - x, s.col + x, 1'b1, done};
    return 4;
  endfunction

  task automatic add_item(input logic func, input logic [15:0] cx, input logic [15:0] cy,
                          input logic [RADIUS_BITS-1:0] radius);
    circle_req_t r;
    span_t junk [4];
    int n;
    r.func = func;
    r.cx = cx;
    r.cy = cy;
    r.radius = radius;
    r.drain = drain_next;
    drain_next = 0;
    n = step_circle(scratch, r, junk);
    if (func == FUNC_START || n > 0) drawing_items++;
    pending_q.push_back(r);
  endtask

  task automatic add_advance();
    add_item(FUNC_ADVANCE, 16'($urandom), 16'($urandom), RADIUS_BITS'($urandom));
  endtask

  task automatic add_circle(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [RADIUS_BITS-1:0] radius, input int max_adv);
    int k;
    k = 0;
    add_item(FUNC_START, cx, cy, radius);
    while (scratch.ph != CIRC_IDLE && k < max_adv) begin
      add_advance();
      k++;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    logic nv;
    circle_req_t nxt;
    nv = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        nv = 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0 && !(pending_q[0].drain && span_q.size() > 0)) begin
        nxt = pending_q.pop_front();
        in_func <= nxt.func;
        in_center_x <= nxt.cx;
        in_center_y <= nxt.cy;
        in_radius <= nxt.radius;
        nv = 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
    in_valid <= nv;
  end

  // receiver stall pattern, with two long hold-offs
  always @(negedge clk) begin
    logic st;
    st = 1'b0;
    if (rst_n) begin
      if (hold_left > 0) begin
        st = 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_done < 2 && accepted_cnt >= 120 + 210 * holds_done) begin
        st = 1'b1;
        hold_left <= 300;
        holds_done <= holds_done + 1;
      end else begin
        case (stall_mode)
          1: st = ($urandom_range(0, 3) == 0);
          2: st = ($urandom_range(0, 3) != 0);
          3: st = ~out_stall;
          default: st = 1'b0;
        endcase
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
    end
    out_stall <= st;
  end

  // monitor and checker
  always @(posedge clk) begin
    circle_req_t cur;
    span_t spans [4];
    span_t want;
    int n;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        cur.func = in_func;
        cur.cx = in_center_x;
        cur.cy = in_center_y;
        cur.radius = in_radius;
        cur.drain = 0;
        n = step_circle(circle, cur, spans);
        for (int i = 0; i < n; i++) span_q.push_back(spans[i]);
        accepted_cnt++;
        if (in_func == FUNC_START) start_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (span_q.size() == 0) begin
          $error("unexpected span transaction: row %0d left %0d right %0d",
                 out_span_row, out_span_left, out_span_right);
          mismatch_cnt++;
        end else begin
          want = span_q.pop_front();
          check_field("span_row", int'($signed(want.row)), int'(out_span_row));
          check_field("span_left", int'($signed(want.left)), int'(out_span_left));
          check_field("span_right", int'($signed(want.right)), int'(out_span_right));
          check_field("last_of_run", int'(want.last), int'(out_last_of_run));
          check_field("circle_done", int'(want.done), int'(out_circle_done));
          spans_checked++;
          if (want.done) circles_done++;
        end
      end
    end
  end

  initial begin
    int pick;
    circle = '{default: '0, ph: CIRC_IDLE};
    scratch = '{default: '0, ph: CIRC_IDLE};

    // directed: idle advance, zero radius, extreme centers and radii, restart mid-circle
    add_advance();
    add_item(FUNC_START, 16'h0000, 16'h0000, 15'd0);
    add_advance();
    add_item(FUNC_START, 16'h7FFF, 16'h8000, 15'd1);
    add_advance();
    add_advance();
    add_item(FUNC_START, 16'h8000, 16'h7FFF, 15'd2);
    repeat (3) add_advance();
    add_item(FUNC_START, 16'hFFFF, 16'h7FFE, 15'h7FFF);
    repeat (3) add_advance();
    add_circle(16'h7FF0, 16'h8008, 15'd3, 100);
    add_circle(16'h8002, 16'h0000, 15'd5, 100);

    drain_next = 1;
    while (drawing_items < 460) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) drain_next = 1;
      if (pick < 75) begin
        add_circle(16'($urandom), 16'($urandom),
                   RADIUS_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(31, 120)
                                                            : $urandom_range(1, 30)),
                   100000);
      end else if (pick < 87) begin
        add_circle(16'($urandom), 16'($urandom), RADIUS_BITS'($urandom),
                   int'($urandom_range(0, 6)));
      end else if (pick < 95) begin
        add_advance();
      end else begin
        add_item(FUNC_START, 16'($urandom), 16'($urandom), RADIUS_BITS'($urandom));
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_q.size() > 0 || in_valid || span_q.size() > 0);
    repeat (20) @(posedge clk);

    $display("Run covered %0d transactions (%0d starts), %0d spans checked, %0d circles done.",
             accepted_cnt, start_cnt, spans_checked, circles_done);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d spans outstanding", span_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
